// ===== sv/rgb_unp_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB666 readback unpacker package
// Shared types and constants for the readback pixel unpacker.
// ----------------------------------------------------------------------------
package rgb_unp_pkg;

  // Width of the pixel countdown. The start count is sized to this width.
  localparam int unsigned CountWidth   = 17;
  localparam int unsigned InCountWidth = 17;
  localparam int unsigned WordWidth    = 16;
  localparam int unsigned PixelWidth   = 16;
  // pixel_count and bus_word packed back to back, padded to whole bytes.
  localparam int unsigned InDataWidth  =
      ((InCountWidth + WordWidth + 7) / 8) * 8;

  typedef enum logic {
    ActStart = 1'b0,
    ActData  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    PhaseDummy = 2'd0,
    PhaseOne   = 2'd1,
    PhaseTwo   = 2'd2,
    PhaseThree = 2'd3
  } phase_e;

  typedef struct packed {
    action_e                 action;
    logic [InCountWidth-1:0] pixel_count;
    logic [WordWidth-1:0]    bus_word;
  } item_t;

  // Input register contents as seen by the unpacking stage.
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

// ===== sv/rgb_unp_in_reg.sv =====
// ----------------------------------------------------------------------------
// RGB666 readback unpacker input register
// Holds one accepted beat until the unpacking stage takes it.
// ----------------------------------------------------------------------------
module rgb_unp_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  rgb_unp_pkg::item_t s_item_i,
  input  logic               take_i,
  output rgb_unp_pkg::stage_t stage_o
);
  import rgb_unp_pkg::*;

  logic  valid_d, valid_q;
  item_t item_q;

  // The register frees up in the same cycle that its beat is taken.
  assign s_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q && !take_i;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= s_item_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

// ===== sv/rgb_unp_core.sv =====
// ----------------------------------------------------------------------------
// RGB666 readback unpacker core
// Tracks the word sequence and pixel count and registers finished pixels.
// ----------------------------------------------------------------------------
module rgb_unp_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rgb_unp_pkg::stage_t                 stage_i,
  output logic                                take_o,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic [rgb_unp_pkg::PixelWidth-1:0]  m_pixel_o,
  output logic                                m_last_o,
  output logic                                left_zero_o
);
  import rgb_unp_pkg::*;

  logic [CountWidth-1:0] left_d, left_q;
  phase_e                phase_d, phase_q;
  logic [WordWidth-1:0]  held_d, held_q;
  logic                  out_valid_d, out_valid_q;
  logic [PixelWidth-1:0] pix_d, pix_q;
  logic                  last_d, last_q;
  logic                  produce;
  logic [WordWidth-1:0]  word;

  assign word = stage_i.item.bus_word;

  // A beat moves on whenever the result register can be loaded.
  assign take_o = stage_i.valid && (!out_valid_q || m_ready_i);

  always_comb begin
    left_d      = left_q;
    phase_d     = phase_q;
    held_d      = held_q;
    pix_d       = pix_q;
    last_d      = last_q;
    produce     = 1'b0;
    out_valid_d = out_valid_q && !m_ready_i;
    if (take_o) begin
      if (stage_i.item.action == ActStart) begin
        left_d  = CountWidth'(stage_i.item.pixel_count);
        phase_d = PhaseDummy;
        held_d  = '0;
      end else if (left_q != '0) begin
        unique case (phase_q)
          PhaseDummy: begin
            phase_d = PhaseOne;
          end
          PhaseOne: begin
            held_d  = word;
            phase_d = PhaseTwo;
          end
          PhaseTwo: begin
            // Red and green from the held word, blue from this one.
            pix_d   = {held_q[15:11], held_q[7:2], word[15:11]};
            held_d  = word;
            phase_d = PhaseThree;
            produce = 1'b1;
          end
          PhaseThree: begin
            // Red from the held word, green and blue from this one.
            pix_d   = {held_q[7:3], word[15:10], word[7:3]};
            phase_d = PhaseOne;
            produce = 1'b1;
          end
          default: begin
            phase_d = PhaseDummy;
          end
        endcase
      end
    end
    if (produce) begin
      left_d      = left_q - CountWidth'(1);
      last_d      = (left_q == CountWidth'(1));
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      phase_q     <= PhaseDummy;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      left_q      <= left_d;
      phase_q     <= phase_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= pix_d;
    last_q <= last_d;
  end

  assign m_valid_o   = out_valid_q;
  assign m_pixel_o   = pix_q;
  assign m_last_o    = last_q;
  assign left_zero_o = (left_q == '0);

endmodule

// ===== sv/readback_rgb666_to_rgb565_unpacker_top.sv =====
// ----------------------------------------------------------------------------
// RGB666 readback to RGB565 unpacker
// Turns 16-bit words read back from an 18-bit color panel into RGB565 pixels.
// ----------------------------------------------------------------------------
// A beat with tuser low starts a read and loads the pixel count from
// tdata[16:0]; a beat with tuser high carries one bus word in tdata[32:17].
// After a start the first data word is a dummy and is dropped. From then on
// every three words give two pixels: the first pixel is completed by the
// second word and the second pixel by the third word, so a pixel leaves on the
// data beat that completes it and tlast marks the final pixel of the read.
// Data words that arrive once the count has run out, or after a start with a
// count of zero, are dropped without effect. A new start abandons any read in
// progress. The block takes one beat every cycle unless the output stalls: a
// beat is held in the input register and the unpacking logic writes its pixel
// into the output register, from which the pixel is offered to the receiver.
// The input ready follows the output ready through the unpacking stage: when
// the input register holds a beat and the output register holds a pixel that
// is not being taken, the input side stalls in that same cycle. Every beat,
// including one that makes no pixel, waits until the output register is free.
// ----------------------------------------------------------------------------
module readback_rgb666_to_rgb565_unpacker_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0 up: pixel_count[16:0], bus_word[32:17], zero pad.
  input  logic [rgb_unp_pkg::InDataWidth-1:0]  s_axis_tdata,
  // Field: action (0 start, 1 data word).
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Field: pixel_rgb565[15:0] (red 15:11, green 10:5, blue 4:0).
  output logic [rgb_unp_pkg::PixelWidth-1:0]   m_axis_tdata,
  // Field: last_pixel.
  output logic                                 m_axis_tlast
);
  import rgb_unp_pkg::*;

  item_t  s_item;
  stage_t stage;
  logic   take;
  logic   left_zero;

  assign s_item.action      = action_e'(s_axis_tuser);
  assign s_item.pixel_count = s_axis_tdata[InCountWidth-1:0];
  assign s_item.bus_word    = s_axis_tdata[InCountWidth+WordWidth-1:InCountWidth];

  rgb_unp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .take_i    (take),
    .stage_o   (stage)
  );

  rgb_unp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .take_o      (take),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_pixel_o   (m_axis_tdata),
    .m_last_o    (m_axis_tlast),
    .left_zero_o (left_zero)
  );

  // The input side only stalls when both registers hold a beat and the
  // output is blocked.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> stage.valid && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a blocked output");

  // While the final pixel of a read is on offer the countdown is exhausted.
  a_last_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> left_zero)
    else $error("last pixel shown while pixels remain");

  // A beat is only taken out of the input register when one is there.
  a_take_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> stage.valid)
    else $error("empty input register consumed");

endmodule
